>>> rtl/core/sbv_pkg.sv
package sbv_pkg;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [31:0] COORD_MAX  = 32'd1048560;
   localparam logic [31:0] START_MAX  = 32'd65535;
   localparam logic [31:0] MAGIC_WORD = {8'h31, 8'h43, 8'h53, 8'h4E};

   localparam int HDR_BYTES  = 32;
   localparam int REC_BYTES  = 24;
   localparam int HASH_FIRST = 28;

   localparam logic [4:0] REC_LAST = 5'(REC_BYTES - 1);
   localparam logic [6:0] INDEX_MAX = 7'd127;

   localparam int Q_DEPTH = 4;

   localparam logic [2:0] HW_MAGIC    = 3'd0;
   localparam logic [2:0] HW_VERSION  = 3'd1;
   localparam logic [2:0] HW_AREA     = 3'd2;
   localparam logic [2:0] HW_COUNT    = 3'd3;
   localparam logic [2:0] HW_START_X  = 3'd4;
   localparam logic [2:0] HW_START_Y  = 3'd5;
   localparam logic [2:0] HW_VERSION2 = 3'd6;
   localparam logic [2:0] HW_HASH     = 3'd7;

   typedef struct packed {
      logic        is_summary;
      logic [6:0]  index;
      logic [7:0]  object_type;
      logic [7:0]  object_variant;
      logic [15:0] object_tag;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] size_w;
      logic [31:0] size_h;
      logic [31:0] object_data;
      logic [2:0]  area;
      logic        ok;
   } result_type;

endpackage

>>> rtl/core/scene_blob_validator.sv
// Streaming checker for a scene blob: one byte is taken per cycle, with the
// final flag on the last byte. The header is checked, FNV-1a runs over every
// byte except the stored hash, each completed 24-byte record is emitted with
// a range check, and the last byte adds a summary with the verdict, after which
// the block is ready for the next blob. Every byte is processed in the cycle
// it is accepted, so the rate is one byte per cycle while the input is not
// stalled; the critical path is the 32-bit hash multiply and compare. Results
// leave through a four-entry queue, and the first result of a byte is offered
// in the cycle after that byte's transfer when the queue was empty. The input
// stalls only while the queue has fewer than two free entries.
module scene_blob_validator #(
   parameter int RECORD_CAPACITY = 64,
   parameter int MAX_BLOB_BYTES  = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_summary,
   output logic [6:0]  rsp_index,
   output logic [7:0]  rsp_object_type,
   output logic [7:0]  rsp_object_variant,
   output logic [15:0] rsp_object_tag,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_size_w,
   output logic [31:0] rsp_size_h,
   output logic [31:0] rsp_object_data,
   output logic [2:0]  rsp_area,
   output logic        rsp_ok
);

   import sbv_pkg::*;

   localparam int POS_W = $clog2(MAX_BLOB_BYTES + 2);
   localparam int CNT_W = $clog2(RECORD_CAPACITY + 1);
   localparam int EXP_W = $clog2(HDR_BYTES + REC_BYTES * RECORD_CAPACITY + 1);
   localparam int CMP_W = (EXP_W > POS_W) ? EXP_W : POS_W;
   localparam int QP_W  = $clog2(Q_DEPTH);
   localparam int QC_W  = $clog2(Q_DEPTH + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      hash_ff, hash_in;
   logic [31:0]      ws_ff, ws_in;
   logic             hg_ff, hg_in;
   logic [2:0]       area_ff, area_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      sx_ff, sx_in;
   logic [15:0]      sy_ff, sy_in;
   logic [31:0]      eh_ff, eh_in;
   logic             rg_ff, rg_in;
   logic [6:0]       rc_ff, rc_in;
   logic [4:0]       rp_ff, rp_in;
   logic [7:0]       rec_ff [0:REC_BYTES-2];

   logic [QP_W-1:0]  qw_ff, qw_in;
   logic [QP_W-1:0]  qr_ff, qr_in;
   logic [QC_W-1:0]  qc_ff, qc_in;
   result_type       q_ff [0:Q_DEPTH-1];

   logic             req_take;
   logic             rsp_take;
   logic             in_range;
   logic             in_hdr;
   logic             hash_skip;
   logic [31:0]      hash_mix;
   logic [31:0]      word_now;
   logic             rec_wr;
   logic             push_rec;
   logic             push_sum;
   logic             acc;
   logic             fok;
   logic [CMP_W-1:0] len_now;
   logic [CMP_W-1:0] len_exp;
   result_type       rec_res;
   result_type       sum_res;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = qc_ff > QC_W'(Q_DEPTH - 2);
   assign rsp_valid = qc_ff != '0;

   assign in_range  = pos_ff < POS_W'(MAX_BLOB_BYTES);
   assign in_hdr    = pos_ff < POS_W'(HDR_BYTES);
   assign hash_skip = (pos_ff >= POS_W'(HASH_FIRST)) && in_hdr;
   assign hash_mix  = (hash_ff ^ {24'd0, req_data_byte}) * FNV_PRIME;
   assign word_now  = {req_data_byte, ws_ff[31:8]};

   always_comb begin
      rec_res                = '0;
      rec_res.is_summary     = 1'b0;
      rec_res.index          = rc_ff;
      rec_res.object_type    = rec_ff[0];
      rec_res.object_variant = rec_ff[1];
      rec_res.object_tag     = {rec_ff[3], rec_ff[2]};
      rec_res.pos_x          = {rec_ff[7], rec_ff[6], rec_ff[5], rec_ff[4]};
      rec_res.pos_y          = {rec_ff[11], rec_ff[10], rec_ff[9], rec_ff[8]};
      rec_res.size_w         = {rec_ff[15], rec_ff[14], rec_ff[13], rec_ff[12]};
      rec_res.size_h         = {rec_ff[19], rec_ff[18], rec_ff[17], rec_ff[16]};
      rec_res.object_data    = {req_data_byte, rec_ff[22], rec_ff[21], rec_ff[20]};
      rec_res.area           = 3'd0;
      fok = (rec_res.object_type <= 8'd3) && (rec_res.object_variant <= 8'd2) &&
            (rec_res.pos_x <= COORD_MAX) && (rec_res.pos_y <= COORD_MAX) &&
            (rec_res.size_w != '0) && (rec_res.size_h != '0) &&
            (rec_res.size_w <= COORD_MAX) && (rec_res.size_h <= COORD_MAX);
      rec_res.ok             = hg_ff && fok;
   end

   always_comb begin
      pos_in   = pos_ff;
      hash_in  = hash_ff;
      ws_in    = ws_ff;
      hg_in    = hg_ff;
      area_in  = area_ff;
      cnt_in   = cnt_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      eh_in    = eh_ff;
      rg_in    = rg_ff;
      rc_in    = rc_ff;
      rp_in    = rp_ff;
      rec_wr   = 1'b0;
      push_rec = 1'b0;
      push_sum = 1'b0;
      acc      = 1'b0;
      len_now  = '0;
      len_exp  = '0;
      sum_res  = '0;
      if (req_take) begin
         if (in_range) begin
            if (!hash_skip) begin
               hash_in = hash_mix;
            end
            if (in_hdr) begin
               ws_in = word_now;
               if (pos_ff[1:0] == 2'd3) begin
                  case (pos_ff[4:2])
                     HW_MAGIC: begin
                        if (word_now != MAGIC_WORD) hg_in = 1'b0;
                     end
                     HW_VERSION, HW_VERSION2: begin
                        if (word_now != 32'd1) hg_in = 1'b0;
                     end
                     HW_AREA: begin
                        if (word_now < 32'd1 || word_now > 32'd4) hg_in = 1'b0;
                        else area_in = word_now[2:0];
                     end
                     HW_COUNT: begin
                        cnt_in = word_now[CNT_W-1:0];
                        if (word_now == '0 || word_now > 32'(RECORD_CAPACITY)) begin
                           hg_in = 1'b0;
                        end
                     end
                     HW_START_X: begin
                        if (word_now > START_MAX) hg_in = 1'b0;
                        else sx_in = word_now[15:0];
                     end
                     HW_START_Y: begin
                        if (word_now > START_MAX) hg_in = 1'b0;
                        else sy_in = word_now[15:0];
                     end
                     HW_HASH: begin
                        eh_in = word_now;
                     end
                     default: begin
                        eh_in = word_now;
                     end
                  endcase
               end
            end else if (rp_ff == REC_LAST) begin
               push_rec = 1'b1;
               rp_in    = '0;
               if (!fok) rg_in = 1'b0;
               if (rc_ff != INDEX_MAX) rc_in = rc_ff + 7'd1;
            end else begin
               rec_wr = 1'b1;
               rp_in  = rp_ff + 5'd1;
            end
         end
         if (pos_ff <= POS_W'(MAX_BLOB_BYTES)) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (req_final_byte) begin
            push_sum = 1'b1;
            len_now  = CMP_W'(pos_in);
            len_exp  = CMP_W'(HDR_BYTES) + CMP_W'(cnt_in) * CMP_W'(REC_BYTES);
            acc = hg_in && rg_in &&
                  (pos_in >= POS_W'(HDR_BYTES)) &&
                  (pos_in <= POS_W'(MAX_BLOB_BYTES)) &&
                  (len_now == len_exp) && (hash_in == eh_in);
            sum_res.is_summary = 1'b1;
            if (acc) begin
               sum_res.index = 7'(cnt_in);
               sum_res.pos_x = {16'd0, sx_in};
               sum_res.pos_y = {16'd0, sy_in};
               sum_res.area  = area_in;
               sum_res.ok    = 1'b1;
            end
            pos_in  = '0;
            hash_in = FNV_OFFSET;
            hg_in   = 1'b1;
            rg_in   = 1'b1;
            rc_in   = '0;
            rp_in   = '0;
         end
      end
   end

   always_comb begin
      qw_in = qw_ff;
      qr_in = qr_ff;
      qc_in = qc_ff;
      if (push_rec && push_sum) begin
         qw_in = qw_ff + QP_W'(2);
         qc_in = qc_in + QC_W'(2);
      end else if (push_rec || push_sum) begin
         qw_in = qw_ff + QP_W'(1);
         qc_in = qc_in + QC_W'(1);
      end
      if (rsp_take) begin
         qr_in = qr_ff + QP_W'(1);
         qc_in = qc_in - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hash_ff <= FNV_OFFSET;
         hg_ff   <= 1'b1;
         rg_ff   <= 1'b1;
         rc_ff   <= '0;
         rp_ff   <= '0;
         qw_ff   <= '0;
         qr_ff   <= '0;
         qc_ff   <= '0;
      end else begin
         pos_ff  <= pos_in;
         hash_ff <= hash_in;
         hg_ff   <= hg_in;
         rg_ff   <= rg_in;
         rc_ff   <= rc_in;
         rp_ff   <= rp_in;
         qw_ff   <= qw_in;
         qr_ff   <= qr_in;
         qc_ff   <= qc_in;
      end
   end

   always_ff @(posedge clock) begin
      ws_ff   <= ws_in;
      area_ff <= area_in;
      cnt_ff  <= cnt_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      eh_ff   <= eh_in;
      if (rec_wr) begin
         rec_ff[rp_ff] <= req_data_byte;
      end
      if (push_rec) begin
         q_ff[qw_ff] <= rec_res;
      end
      if (push_sum) begin
         if (push_rec) q_ff[qw_ff + QP_W'(1)] <= sum_res;
         else q_ff[qw_ff] <= sum_res;
      end
   end

   assign rsp_is_summary     = q_ff[qr_ff].is_summary;
   assign rsp_index          = q_ff[qr_ff].index;
   assign rsp_object_type    = q_ff[qr_ff].object_type;
   assign rsp_object_variant = q_ff[qr_ff].object_variant;
   assign rsp_object_tag     = q_ff[qr_ff].object_tag;
   assign rsp_pos_x          = q_ff[qr_ff].pos_x;
   assign rsp_pos_y          = q_ff[qr_ff].pos_y;
   assign rsp_size_w         = q_ff[qr_ff].size_w;
   assign rsp_size_h         = q_ff[qr_ff].size_h;
   assign rsp_object_data    = q_ff[qr_ff].object_data;
   assign rsp_area           = q_ff[qr_ff].area;
   assign rsp_ok             = q_ff[qr_ff].ok;

endmodule
